// ===== rtl/core/power_meter_frame_checker_core_defines.svh =====
// ----------------------------------------------------------------------------
// power_meter_frame_checker_core_defines.svh
// Assertion macros for the frame checker core.
// ----------------------------------------------------------------------------
`ifndef POWER_METER_FRAME_CHECKER_CORE_DEFINES_SVH
`define POWER_METER_FRAME_CHECKER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define PMFC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("pmfc assertion failed");

// Next-cycle implication
`define PMFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("pmfc assertion failed");

`else

`define PMFC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define PMFC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/pmfc_pkg.sv =====
// ----------------------------------------------------------------------------
// pmfc_pkg
// Shared types, constants and helpers for the frame checker.
// ----------------------------------------------------------------------------
package pmfc_pkg;

	// Framing marks
	localparam logic [7:0]  START_MARK = 8'h68;
	localparam logic [7:0]  END_MARK   = 8'h16;
	localparam logic [15:0] PROTO_MASK = 16'h0003;
	localparam logic [15:0] PROTO_CODE = 16'h0002;

	// Byte offsets within a frame
	localparam logic [15:0] POS_START1 = 16'd0;
	localparam logic [15:0] POS_LEN_LO = 16'd1;
	localparam logic [15:0] POS_LEN_HI = 16'd2;
	localparam logic [15:0] POS_START2 = 16'd5;
	localparam logic [15:0] POS_CTRL   = 16'd6;
	localparam logic [15:0] POS_FUNC   = 16'd12;
	localparam logic [15:0] POS_SEQ    = 16'd13;
	localparam logic [15:0] POS_MAX    = 16'hFFFF;

	// Shortest legal frame: position of its last byte is MIN_FRAME - 1
	localparam logic [15:0] MIN_LAST_POS = 16'd15;
	// Fixed overhead outside the user data, less one for position vs length
	localparam logic [16:0] OVERHEAD_M1  = 17'd7;

	localparam int ULEN_W = 14;

	// Result status codes
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SHORT     = 3'd1,
		ST_BAD_START = 3'd2,
		ST_BAD_END   = 3'd3,
		ST_BAD_PROTO = 3'd4,
		ST_OVERRUN   = 3'd5,
		ST_CHECKSUM  = 3'd6,
		ST_BAD_FUNC  = 3'd7
	} status_t;

	// Frame state as it stands after the current byte, handed to the status check
	typedef struct packed {
		logic [15:0] pos;
		logic [7:0]  data;
		logic        start_ok;
		logic [15:0] length_word;
		logic [7:0]  prev;
		logic [7:0]  sum;
		logic [7:0]  func;
	} chk_in_t;

	// Supported application function codes
	function automatic logic func_supported(input logic [7:0] f);
		func_supported = (f == 8'h00) || (f == 8'h04) || (f == 8'h0A) ||
			(f == 8'h0C) || (f == 8'h0D) || (f == 8'h0E);
	endfunction

endpackage

// ===== rtl/core/pmfc_status.sv =====
// ----------------------------------------------------------------------------
// pmfc_status
// Prioritised status decode for a completed frame.
// ----------------------------------------------------------------------------
module pmfc_status (
	input  pmfc_pkg::chk_in_t chk,
	output pmfc_pkg::status_t status
);

	logic [pmfc_pkg::ULEN_W-1:0] ulen;
	logic [16:0]                 ulen_end;

	assign ulen     = chk.length_word[15:2];
	// last position is p, frame length p+1; overrun when ulen + 8 > p + 1
	assign ulen_end = 17'(ulen) + pmfc_pkg::OVERHEAD_M1;

	// Checks in priority order
	always_comb begin
		if (chk.pos < pmfc_pkg::MIN_LAST_POS) begin
			status = pmfc_pkg::ST_SHORT;
		end else if (!chk.start_ok) begin
			status = pmfc_pkg::ST_BAD_START;
		end else if (chk.data != pmfc_pkg::END_MARK) begin
			status = pmfc_pkg::ST_BAD_END;
		end else if ((chk.length_word & pmfc_pkg::PROTO_MASK) != pmfc_pkg::PROTO_CODE) begin
			status = pmfc_pkg::ST_BAD_PROTO;
		end else if (ulen_end > {1'b0, chk.pos}) begin
			status = pmfc_pkg::ST_OVERRUN;
		end else if (chk.prev != chk.sum) begin
			status = pmfc_pkg::ST_CHECKSUM;
		end else if (!pmfc_pkg::func_supported(chk.func)) begin
			status = pmfc_pkg::ST_BAD_FUNC;
		end else begin
			status = pmfc_pkg::ST_OK;
		end
	end

endmodule

// ===== rtl/core/power_meter_frame_checker_core.sv =====
// ----------------------------------------------------------------------------
// power_meter_frame_checker_core
// Byte-stream checker for 376.1 style power-meter frames.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel: one frame byte per request on data_byte, with last_byte
//  set on the closing byte. Output channel: one result per frame, carrying
//  the status code and the captured control, function and SEQ fields.
//  Both channels use valid/stall; a request moves when valid is high and
//  stall is low.
//  Throughput: one byte per cycle while the receiver does not stall. Each
//  byte is registered, then the frame state and status are updated from
//  that register. The result for a frame passes from the input register
//  through the result register to out_valid.
//  While the receiver stalls with a result waiting, the input register
//  holds and in_stall rises once it is occupied.
//  Reset clears the frame state and the valid bits of both registers; the
//  next byte taken is treated as the first byte of a frame. After every
//  last byte the frame state returns to its reset value.
// ----------------------------------------------------------------------------
`include "power_meter_frame_checker_core_defines.svh"

module power_meter_frame_checker_core (
	input  logic                        clk,
	input  logic                        arst_n,
	// Byte input
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  data_byte,
	input  logic                        last_byte,
	// Frame result
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [2:0]                  status,
	output logic [7:0]                  control_byte,
	output logic [7:0]                  function_code,
	output logic [7:0]                  sequence_byte,
	output logic [pmfc_pkg::ULEN_W-1:0] user_length,
	output logic                        more_frames,
	output logic                        has_time_tag,
	output logic                        has_event_counter
);

	// Input register
	logic       s1_valid;
	logic [7:0] s1_data;
	logic       s1_last;

	// Frame state
	logic [15:0] pos_q;
	logic [15:0] len_q;
	logic [7:0]  sum_q;
	logic [7:0]  prev_q;
	logic        sok_q;
	logic [7:0]  ctrl_q;
	logic [7:0]  func_q;
	logic [7:0]  seq_q;

	// Result register
	logic                        out_valid_q;
	pmfc_pkg::status_t           status_q;
	logic [7:0]                  ctrl_out_q;
	logic [7:0]                  func_out_q;
	logic [7:0]                  seq_out_q;
	logic [pmfc_pkg::ULEN_W-1:0] ulen_out_q;

	// Next state for the byte in s1
	logic                        out_free;
	logic                        adv;
	logic                        sok_n;
	logic [15:0]                 len_n;
	logic [7:0]                  ctrl_n;
	logic [7:0]                  func_n;
	logic [7:0]                  seq_n;
	logic [7:0]                  sum_n;
	logic [pmfc_pkg::ULEN_W-1:0] ulen_n;
	logic [16:0]                 user_lim;
	logic                        sum_en;
	pmfc_pkg::chk_in_t           chk;
	pmfc_pkg::status_t           status_n;

	// Handshake: s1 drains whenever the result register can take a request
	assign out_free = !out_valid_q || !out_stall;
	assign adv      = s1_valid && out_free;
	assign in_stall = s1_valid && !out_free;

	// Field capture at fixed offsets
	always_comb begin
		sok_n  = sok_q;
		len_n  = len_q;
		ctrl_n = ctrl_q;
		func_n = func_q;
		seq_n  = seq_q;
		if ((pos_q == pmfc_pkg::POS_START1 || pos_q == pmfc_pkg::POS_START2) &&
			s1_data != pmfc_pkg::START_MARK) begin
			sok_n = 1'b0;
		end
		if (pos_q == pmfc_pkg::POS_LEN_LO) begin
			len_n[7:0] = s1_data;
		end
		if (pos_q == pmfc_pkg::POS_LEN_HI) begin
			len_n[15:8] = s1_data;
		end
		if (pos_q == pmfc_pkg::POS_CTRL) begin
			ctrl_n = s1_data;
		end
		if (pos_q == pmfc_pkg::POS_FUNC) begin
			func_n = s1_data;
		end
		if (pos_q == pmfc_pkg::POS_SEQ) begin
			seq_n = s1_data;
		end
	end

	// Checksum over user bytes: positions from the control byte for ulen bytes
	assign ulen_n   = len_n[15:2];
	assign user_lim = 17'(pmfc_pkg::POS_CTRL) + 17'(ulen_n);
	assign sum_en   = (pos_q >= pmfc_pkg::POS_CTRL) && ({1'b0, pos_q} < user_lim);
	assign sum_n    = sum_en ? sum_q + s1_data : sum_q;

	assign chk.pos         = pos_q;
	assign chk.data        = s1_data;
	assign chk.start_ok    = sok_n;
	assign chk.length_word = len_n;
	assign chk.prev        = prev_q;
	assign chk.sum         = sum_n;
	assign chk.func        = func_n;

	pmfc_status u_status (
		.chk    (chk),
		.status (status_n)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (!in_stall) begin
			s1_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			s1_data <= data_byte;
			s1_last <= last_byte;
		end
	end

	// Frame state: advance per byte, back to reset after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			len_q  <= '0;
			sum_q  <= '0;
			prev_q <= '0;
			sok_q  <= 1'b1;
			ctrl_q <= '0;
			func_q <= '0;
			seq_q  <= '0;
		end else if (adv) begin
			if (s1_last) begin
				pos_q  <= '0;
				len_q  <= '0;
				sum_q  <= '0;
				prev_q <= '0;
				sok_q  <= 1'b1;
				ctrl_q <= '0;
				func_q <= '0;
				seq_q  <= '0;
			end else begin
				if (pos_q != pmfc_pkg::POS_MAX) begin
					pos_q <= pos_q + 16'd1;
				end
				len_q  <= len_n;
				sum_q  <= sum_n;
				prev_q <= s1_data;
				sok_q  <= sok_n;
				ctrl_q <= ctrl_n;
				func_q <= func_n;
				seq_q  <= seq_n;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_valid && s1_last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s1_last) begin
			status_q   <= status_n;
			ctrl_out_q <= ctrl_n;
			func_out_q <= func_n;
			seq_out_q  <= seq_n;
			ulen_out_q <= ulen_n;
		end
	end

	// Outputs, flags decoded from the held fields
	assign out_valid         = out_valid_q;
	assign status            = status_q;
	assign control_byte      = ctrl_out_q;
	assign function_code     = func_out_q;
	assign sequence_byte     = seq_out_q;
	assign user_length       = ulen_out_q;
	assign more_frames       = !seq_out_q[5];
	assign has_time_tag      = seq_out_q[7];
	assign has_event_counter = ctrl_out_q[7] && ctrl_out_q[5];

	// Checks
	`PMFC_ASSERT_IMPLIES(a_stall_cause, clk, arst_n, in_stall, s1_valid && out_valid_q && out_stall)
	`PMFC_ASSERT_NEXT(a_frame_restart, clk, arst_n, adv && s1_last, pos_q == '0 && sok_q && sum_q == '0)
	`PMFC_ASSERT_IMPLIES(a_ok_func, clk, arst_n, out_valid_q && status_q == pmfc_pkg::ST_OK, pmfc_pkg::func_supported(func_out_q))
	`PMFC_ASSERT_NEXT(a_result_from_last, clk, arst_n, adv && !s1_last && !out_valid_q, !out_valid_q)

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for power_meter_frame_checker_core. Frames go in one
// byte at a time. A scoreboard class predicts the status and captured fields
// of each frame and checks every result against the oldest prediction. Short
// directed frames come first: every supported function, each error status,
// the protocol-bit and length extremes and the unchecked length copy. Then
// come mostly well-formed random frames with occasional flaws, raw frames
// and noise. Sender idling and receiver stalls are varied over three phases.
// ----------------------------------------------------------------------------
module testbench;

	// Framing marks and byte offsets
	localparam logic [7:0] START_BYTE = 8'h68;
	localparam logic [7:0] END_BYTE   = 8'h16;
	localparam logic [1:0] PROTO_ID   = 2'b10;
	localparam int OFS_START1   = 0;
	localparam int OFS_LEN_LO   = 1;
	localparam int OFS_LEN_HI   = 2;
	localparam int OFS_COPY_LO  = 3;
	localparam int OFS_COPY_HI  = 4;
	localparam int OFS_START2   = 5;
	localparam int OFS_CTRL     = 6;
	localparam int OFS_FUNC     = 12;
	localparam int OFS_SEQ      = 13;
	localparam int MIN_FRAME    = 16;
	localparam int TRAILER      = 8;

	// Flag bit positions in control and SEQ
	localparam int CTRL_DIR_BIT = 7;
	localparam int CTRL_ACD_BIT = 5;
	localparam int SEQ_TPV_BIT  = 7;
	localparam int SEQ_FIN_BIT  = 5;

	// Application function codes
	localparam logic [7:0] FN_CONFIRM     = 8'h00;
	localparam logic [7:0] FN_RESET       = 8'h01;
	localparam logic [7:0] FN_SET_PARAM   = 8'h04;
	localparam logic [7:0] FN_QUERY_PARAM = 8'h0A;
	localparam logic [7:0] FN_CLASS1_DATA = 8'h0C;
	localparam logic [7:0] FN_CLASS2_DATA = 8'h0D;
	localparam logic [7:0] FN_CLASS3_DATA = 8'h0E;
	localparam logic [7:0] FUNC_CODES [6] = '{FN_CONFIRM, FN_SET_PARAM, FN_QUERY_PARAM,
		FN_CLASS1_DATA, FN_CLASS2_DATA, FN_CLASS3_DATA};

	// Control and SEQ patterns for the directed frames, flag bits at both levels
	localparam logic [7:0] CTRL_PICKS [6] = '{8'hFF, 8'h00, 8'hA0, 8'h80, 8'h20, 8'h5A};
	localparam logic [7:0] SEQ_PICKS  [6] = '{8'hFF, 8'h00, 8'h20, 8'h80, 8'h60, 8'hA5};

	// Ways of spoiling a well-formed frame
	typedef enum int {
		FLAW_START1, FLAW_START2, FLAW_END, FLAW_PROTO, FLAW_SUM, FLAW_CUT
	} flaw_t;

	typedef logic [7:0] octet_q_t[$];

	typedef struct packed {
		pmfc_pkg::status_t           status;
		logic [7:0]                  ctrl;
		logic [7:0]                  func;
		logic [7:0]                  seq;
		logic [pmfc_pkg::ULEN_W-1:0] ulen;
		logic                        more;
		logic                        ttag;
		logic                        evc;
	} frame_verdict_t;

	// Tracks frame state byte by byte and holds the verdicts still owed
	class frame_verdict_board;
		logic [15:0] pos;
		logic [15:0] len_word;
		logic [7:0]  user_sum;
		logic [7:0]  prev_byte;
		logic        starts_ok;
		logic [7:0]  ctrl_q;
		logic [7:0]  func_q;
		logic [7:0]  seq_q;
		frame_verdict_t pending_verdicts[$];
		int mismatches;
		int frames_checked;
		int status_seen[8];

		function new();
			clear_frame();
			mismatches = 0;
			frames_checked = 0;
			foreach (status_seen[i])
				status_seen[i] = 0;
		endfunction

		function void clear_frame();
			pos = 16'd0;
			len_word = 16'd0;
			user_sum = 8'd0;
			prev_byte = 8'd0;
			starts_ok = 1'b1;
			ctrl_q = 8'd0;
			func_q = 8'd0;
			seq_q = 8'd0;
		endfunction

		function bit func_known(logic [7:0] f);
			foreach (FUNC_CODES[i])
				if (f == FUNC_CODES[i])
					return 1'b1;
			return 1'b0;
		endfunction

		// Note an accepted byte; on the last byte of a frame queue its verdict
		function void take_byte(logic [7:0] b, logic last);
			frame_verdict_t v;
			logic [13:0] ulen;
			int flen;
			if ((pos == OFS_START1 || pos == OFS_START2) && b != START_BYTE)
				starts_ok = 1'b0;
			if (pos == OFS_LEN_LO)
				len_word[7:0] = b;
			if (pos == OFS_LEN_HI)
				len_word[15:8] = b;
			if (pos == OFS_CTRL)
				ctrl_q = b;
			if (pos == OFS_FUNC)
				func_q = b;
			if (pos == OFS_SEQ)
				seq_q = b;
			ulen = len_word[15:2];
			if (int'(pos) >= OFS_CTRL && int'(pos) < OFS_CTRL + int'(ulen))
				user_sum = user_sum + b;
			if (!last) begin
				prev_byte = b;
				if (pos != 16'hFFFF)
					pos = pos + 16'd1;
				return;
			end
			flen = int'(pos) + 1;
			// Checks in priority order
			if (flen < MIN_FRAME)
				v.status = pmfc_pkg::ST_SHORT;
			else if (!starts_ok)
				v.status = pmfc_pkg::ST_BAD_START;
			else if (b != END_BYTE)
				v.status = pmfc_pkg::ST_BAD_END;
			else if (len_word[1:0] != PROTO_ID)
				v.status = pmfc_pkg::ST_BAD_PROTO;
			else if (int'(ulen) + TRAILER > flen)
				v.status = pmfc_pkg::ST_OVERRUN;
			else if (prev_byte != user_sum)
				v.status = pmfc_pkg::ST_CHECKSUM;
			else if (!func_known(func_q))
				v.status = pmfc_pkg::ST_BAD_FUNC;
			else
				v.status = pmfc_pkg::ST_OK;
			v.ctrl = ctrl_q;
			v.func = func_q;
			v.seq = seq_q;
			v.ulen = ulen;
			v.more = ~seq_q[SEQ_FIN_BIT];
			v.ttag = seq_q[SEQ_TPV_BIT];
			v.evc = ctrl_q[CTRL_DIR_BIT] & ctrl_q[CTRL_ACD_BIT];
			pending_verdicts.push_back(v);
			clear_frame();
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH: %s", msg);
			mismatches++;
		endtask

		task compare_field(string name, logic [15:0] got, logic [15:0] want);
			if (got !== want)
				report_mismatch($sformatf("frame %0d %s: got 0x%0h, want 0x%0h",
					frames_checked, name, got, want));
		endtask

		// Compare one result with the oldest verdict owed
		task check_verdict(frame_verdict_t got);
			frame_verdict_t want;
			if (pending_verdicts.size() == 0) begin
				report_mismatch($sformatf("result with no frame pending, status %0d",
					got.status));
				return;
			end
			want = pending_verdicts.pop_front();
			status_seen[want.status]++;
			compare_field("status", 16'(got.status), 16'(want.status));
			compare_field("control_byte", 16'(got.ctrl), 16'(want.ctrl));
			compare_field("function_code", 16'(got.func), 16'(want.func));
			compare_field("sequence_byte", 16'(got.seq), 16'(want.seq));
			compare_field("user_length", 16'(got.ulen), 16'(want.ulen));
			compare_field("more_frames", 16'(got.more), 16'(want.more));
			compare_field("has_time_tag", 16'(got.ttag), 16'(want.ttag));
			compare_field("has_event_counter", 16'(got.evc), 16'(want.evc));
			frames_checked++;
		endtask
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic [7:0]                    data_byte;
	logic                          last_byte;
	logic                          out_valid;
	logic                          out_stall;
	logic [2:0]                    status;
	logic [7:0]                    control_byte;
	logic [7:0]                    function_code;
	logic [7:0]                    sequence_byte;
	logic [pmfc_pkg::ULEN_W-1:0]   user_length;
	logic                          more_frames;
	logic                          has_time_tag;
	logic                          has_event_counter;

	frame_verdict_board board;
	int tx_idle_pct;
	int rx_stall_pct;
	int bytes_sent;

	power_meter_frame_checker_core dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.data_byte         (data_byte),
		.last_byte         (last_byte),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.status            (status),
		.control_byte      (control_byte),
		.function_code     (function_code),
		.sequence_byte     (sequence_byte),
		.user_length       (user_length),
		.more_frames       (more_frames),
		.has_time_tag      (has_time_tag),
		.has_event_counter (has_event_counter)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		#5000000;
		$display("*** FAILED ***");
		$finish;
	end

	// Receiver back-pressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < rx_stall_pct);
	end

	// Watch both channels; requests count on the edge where valid and not stall
	always @(posedge clk) begin : watch
		frame_verdict_t got;
		if (arst_n && in_valid && !in_stall)
			board.take_byte(data_byte, last_byte);
		if (arst_n && out_valid && !out_stall) begin
			got.status = pmfc_pkg::status_t'(status);
			got.ctrl = control_byte;
			got.func = function_code;
			got.seq = sequence_byte;
			got.ulen = user_length;
			got.more = more_frames;
			got.ttag = has_time_tag;
			got.evc = has_event_counter;
			board.check_verdict(got);
		end
	end

	function automatic logic [7:0] other_than(input logic [7:0] avoid);
		logic [7:0] b;
		b = 8'($urandom);
		if (b == avoid)
			b = b ^ 8'h01;
		return b;
	endfunction

	// Well-formed frame: user data checksummed, pad bytes outside the sum
	function automatic octet_q_t build_frame(input logic [13:0] ulen, input logic [1:0] pbits,
		input logic [7:0] ctrl, input logic [7:0] fn, input logic [7:0] seq, input int pad);
		octet_q_t f;
		logic [15:0] lw;
		logic [7:0] cs;
		logic [7:0] b;
		lw = {ulen, pbits};
		cs = 8'h00;
		f = '{START_BYTE, lw[7:0], lw[15:8], lw[7:0], lw[15:8], START_BYTE};
		for (int i = OFS_CTRL; i < OFS_CTRL + int'(ulen) + pad; i++) begin
			case (i)
				OFS_CTRL: b = ctrl;
				OFS_FUNC: b = fn;
				OFS_SEQ:  b = seq;
				default:  b = 8'($urandom);
			endcase
			if (i < OFS_CTRL + int'(ulen))
				cs = cs + b;
			f.push_back(b);
		end
		f.push_back(cs);
		f.push_back(END_BYTE);
		return f;
	endfunction

	// Proper header and end mark around random bytes
	function automatic octet_q_t raw_frame(input logic [15:0] lw, input int n);
		octet_q_t f;
		f = '{START_BYTE, lw[7:0], lw[15:8], lw[7:0], lw[15:8], START_BYTE};
		while (f.size() < n - 1)
			f.push_back(8'($urandom));
		f.push_back(END_BYTE);
		return f;
	endfunction

	// Mostly sound frames, some spoilt, some raw, some plain noise
	function automatic octet_q_t random_frame();
		octet_q_t f;
		int pick;
		int pad;
		logic [13:0] ulen;
		logic [7:0] fn;
		pick = $urandom_range(99);
		if (pick >= 85) begin
			repeat ($urandom_range(1, 24))
				f.push_back(8'($urandom));
			return f;
		end
		if (pick >= 70)
			return raw_frame(16'($urandom), $urandom_range(16, 40));
		pad = ($urandom_range(9) < 7) ? 0 : $urandom_range(1, 3);
		pick = $urandom_range(99);
		if (pick < 70) begin
			ulen = 14'($urandom_range(8, 40));
		end else if (pick < 85) begin
			// user length below the fixed header, padded up to a full frame
			ulen = 14'($urandom_range(0, 7));
			pad = 8 - int'(ulen) + $urandom_range(0, 4);
		end else begin
			ulen = 14'($urandom_range(41, 120));
		end
		fn = ($urandom_range(99) < 80) ? FUNC_CODES[$urandom_range(5)] : 8'($urandom);
		f = build_frame(ulen, PROTO_ID, 8'($urandom), fn, 8'($urandom), pad);
		if ($urandom_range(99) < 25) begin
			case (flaw_t'($urandom_range(5)))
				FLAW_START1: f[OFS_START1] = other_than(START_BYTE);
				FLAW_START2: f[OFS_START2] = other_than(START_BYTE);
				FLAW_END:    f[f.size() - 1] = other_than(END_BYTE);
				FLAW_PROTO:  f[OFS_LEN_LO] = f[OFS_LEN_LO] ^ {6'd0, 2'($urandom_range(1, 3))};
				FLAW_SUM:    f[f.size() - 2] = f[f.size() - 2] ^ 8'($urandom_range(1, 255));
				default: begin
					repeat ($urandom_range(1, 4))
						f.delete(OFS_CTRL + 1);
				end
			endcase
		end
		return f;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_frame(input octet_q_t f);
		for (int i = 0; i < f.size(); i++)
			send_byte(f[i], i == f.size() - 1);
	endtask

	// Hold the sender until every owed verdict has been checked
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_directed();
		octet_q_t f;
		// each supported function in a minimum-length frame, flag bits both ways
		foreach (FUNC_CODES[i])
			send_frame(build_frame(14'd8, PROTO_ID, CTRL_PICKS[i], FUNC_CODES[i],
				SEQ_PICKS[i], 0));
		// one byte under the minimum, then a lone byte
		send_frame(build_frame(14'd7, PROTO_ID, 8'hA0, FN_CONFIRM, 8'h00, 0));
		send_byte(END_BYTE, 1'b1);
		// bad first start byte outranks bad end
		f = build_frame(14'd10, PROTO_ID, 8'h12, FN_SET_PARAM, 8'h34, 0);
		f[OFS_START1] = 8'h69;
		f[f.size() - 1] = 8'h00;
		send_frame(f);
		f = build_frame(14'd10, PROTO_ID, 8'h12, FN_SET_PARAM, 8'h34, 0);
		f[OFS_START2] = 8'h00;
		send_frame(f);
		f = build_frame(14'd10, PROTO_ID, 8'h12, FN_SET_PARAM, 8'h34, 0);
		f[f.size() - 1] = 8'hFF;
		send_frame(f);
		// every wrong protocol id
		for (int k = 0; k < 4; k++)
			if (2'(k) != PROTO_ID)
				send_frame(build_frame(14'd9, 2'(k), 8'hC3, FN_CLASS1_DATA, 8'h3C, 0));
		// user data cut short of the stated length
		f = build_frame(14'd20, PROTO_ID, 8'h55, FN_CLASS2_DATA, 8'hAA, 0);
		repeat (5)
			f.delete(OFS_CTRL + 1);
		send_frame(f);
		f = build_frame(14'd12, PROTO_ID, 8'h55, FN_CLASS2_DATA, 8'hAA, 0);
		f[f.size() - 2] = f[f.size() - 2] ^ 8'h01;
		send_frame(f);
		// unsupported functions, 0xFF being the top of the range
		send_frame(build_frame(14'd8, PROTO_ID, 8'h0F, FN_RESET, 8'hF0, 0));
		send_frame(build_frame(14'd8, PROTO_ID, 8'h0F, 8'hFF, 8'hF0, 0));
		// user length below the fixed header: fields still from fixed offsets
		send_frame(build_frame(14'd0, PROTO_ID, 8'hA5, FN_QUERY_PARAM, 8'h81, 8));
		send_frame(build_frame(14'd3, PROTO_ID, 8'hA5, FN_CLASS3_DATA, 8'h81, 10));
		// length copy is not checked
		f = build_frame(14'd12, PROTO_ID, 8'h77, FN_CONFIRM, 8'h99, 0);
		f[OFS_COPY_LO] = ~f[OFS_COPY_LO];
		f[OFS_COPY_HI] = f[OFS_COPY_HI] ^ 8'h80;
		send_frame(f);
		// largest length words in frames far too short for them
		send_frame(raw_frame(16'hFFFF, 24));
		send_frame(raw_frame(16'hFFFE, 24));
	endtask

	task automatic run_random(input int n);
		int target;
		target = bytes_sent + n;
		while (bytes_sent < target)
			send_frame(random_frame());
	endtask

	initial begin
		board = new();
		bytes_sent = 0;
		tx_idle_pct = 35;
		rx_stall_pct = 64;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		data_byte <= 8'h00;
		last_byte <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_random(340);
		drain_results();

		tx_idle_pct = 64;
		rx_stall_pct = 35;
		run_random(340);
		drain_results();

		tx_idle_pct = 0;
		rx_stall_pct = 0;
		run_random(330);

		drain_results();
		repeat (6) @(posedge clk);
		$display("Checked %0d frames from %0d bytes over three idling phases, %0d mismatches.",
			board.frames_checked, bytes_sent, board.mismatches);
		$display({"Status counts ok/short/start/end/proto/overrun/sum/func: ",
			"%0d %0d %0d %0d %0d %0d %0d %0d"},
			board.status_seen[pmfc_pkg::ST_OK], board.status_seen[pmfc_pkg::ST_SHORT],
			board.status_seen[pmfc_pkg::ST_BAD_START], board.status_seen[pmfc_pkg::ST_BAD_END],
			board.status_seen[pmfc_pkg::ST_BAD_PROTO], board.status_seen[pmfc_pkg::ST_OVERRUN],
			board.status_seen[pmfc_pkg::ST_CHECKSUM], board.status_seen[pmfc_pkg::ST_BAD_FUNC]);
		if (board.mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
